@@ hdl/periodic_task_timer_table_top_macros.svh @@
// Assertion macros used by the checker file of the timer table.
`ifndef PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ptt_pkg.sv @@
// Package: command and result codes, sequencer states and shared types of the timer table.
`default_nettype none
package ptt_pkg;

	localparam int PERIOD_W = 32;
	localparam int REM_W    = 34;
	localparam int ID_W     = 4;

	// Input command codes
	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_SERVICE = 3'd1,
		CMD_ADD     = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_SLEEP   = 3'd4
	} ptt_cmd_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_FIRED   = 3'd0,
		KIND_ADDED   = 3'd1,
		KIND_FULL    = 3'd2,
		KIND_REMOVED = 3'd3,
		KIND_INVALID = 3'd4
	} ptt_kind_t;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_ADD     = 5'b00010,
		ST_SVC_CHK = 5'b00100,
		ST_SVC_EX  = 5'b01000,
		ST_FLUSH   = 5'b10000
	} ptt_state_t;

	// Write request into the slot store
	typedef struct packed {
		logic                       we;
		logic [PERIOD_W-1:0]        period;
		logic signed [REM_W-1:0]    remaining;
	} ptt_mem_wr_t;

endpackage
`default_nettype wire

@@ hdl/ptt_slot_mem.sv @@
// Slot store: period and remaining count per slot, one write and one registered read port.
`default_nettype none
module ptt_slot_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic                                 clk,
	input  wire logic [ADDR_W-1:0]                    wr_addr,
	input  wire ptt_pkg::ptt_mem_wr_t                 wr,
	input  wire logic                                 rd_en,
	input  wire logic [ADDR_W-1:0]                    rd_addr,
	output      logic [ptt_pkg::PERIOD_W-1:0]         rd_period,
	output      logic signed [ptt_pkg::REM_W-1:0]     rd_remaining
);

	logic [ptt_pkg::PERIOD_W-1:0]     period_mem [DEPTH];
	logic signed [ptt_pkg::REM_W-1:0] rem_mem    [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			period_mem[wr_addr] <= wr.period;
			rem_mem[wr_addr]    <= wr.remaining;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_period    <= period_mem[rd_addr];
			rd_remaining <= rem_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/periodic_task_timer_table_top.sv @@
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transaction: tick,
//   service, add, remove or set sleep mark. Output channel (out_valid/out_stall)
//   carries results (kind, slot_id, last); last marks the final result of a command.
// Command flow:
//   The block takes one command at a time and holds in_stall high while busy.
//   Tick, and set sleep on a valid slot, give no result. Remove and invalid set
//   sleep give one result; add walks the slots from slot 0 to the lowest free one,
//   or through all SLOT_CAP slots when the table is full. Service walks the slots
//   with one shared subtract/compare unit: a check step per skipped slot, a check
//   step (store read) then an update step per active slot, then a flush step; a
//   one-shot fire ends it early. A fire result is held until the next fire or the
//   end of the command, so the last flag can be set on the final one.
// Reset:
//   arst_n low clears the table marks, pending ticks and both valid flags.
//   Period and remaining counts are only read for slots that add has written.
// Stall:
//   A single output register parts the channels; while out_stall holds a result,
//   the walk pauses on the next result it has to hand over.
`default_nettype none
module periodic_task_timer_table_top #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] interval,
	input  wire logic        one_shot,
	input  wire logic [3:0]  slot,
	input  wire logic        sleep_on,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [2:0]  kind,
	output      logic [3:0]  slot_id,
	output      logic        last
);

	localparam int SLOT_CAP = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
	localparam int IDX_W    = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_CAP - 1);

	ptt_pkg::ptt_state_t state_q;
	logic [SLOT_CAP-1:0] valid_q, sleep_q, once_q;
	logic [31:0]         pending_q, elapsed_q, add_period_q;
	logic                add_once_q;
	logic [IDX_W-1:0]    walk_q;
	logic                hold_valid_q;
	ptt_pkg::ptt_kind_t  hold_kind_q;
	logic [3:0]          hold_id_q;
	logic                out_valid_q, out_last_q;
	logic [2:0]          out_kind_q;
	logic [3:0]          out_id_q;

	logic                                 slot_ok, slot_hit, active, walk_end;
	logic                                 out_free, fire, ex_go, push, push_last;
	logic [IDX_W-1:0]                     slot_idx;
	logic [ptt_pkg::PERIOD_W-1:0]         rd_period;
	logic signed [ptt_pkg::REM_W-1:0]     rd_remaining, diff;
	ptt_pkg::ptt_mem_wr_t                 mem_wr;
	logic                                 rd_en;

	// addressed slot checks
	assign slot_ok  = {1'b0, slot} < 5'(SLOT_CAP);
	assign slot_idx = slot[IDX_W-1:0];
	assign slot_hit = slot_ok && valid_q[slot_idx];

	// walk position checks
	assign active   = valid_q[walk_q] && !sleep_q[walk_q];
	assign walk_end = (walk_q == LAST_IDX);

	// shared subtract and compare
	assign diff = rd_remaining - $signed({2'b00, elapsed_q});
	assign fire = diff[ptt_pkg::REM_W-1] || (diff == '0);

	assign out_free = !out_valid_q || !out_stall;
	assign ex_go    = (state_q == ptt_pkg::ST_SVC_EX) && (!fire || !hold_valid_q || out_free);

	// held result goes out on a new fire or at the end of the command
	assign push_last = (state_q == ptt_pkg::ST_FLUSH);
	assign push = hold_valid_q &&
		((ex_go && fire) || (push_last && out_free));

	assign in_stall = (state_q != ptt_pkg::ST_IDLE);
	assign rd_en    = (state_q == ptt_pkg::ST_SVC_CHK) && active;

	// store write: new slot on add, updated count on service
	always_comb begin
		mem_wr.we        = 1'b0;
		mem_wr.period    = add_period_q;
		mem_wr.remaining = $signed({2'b00, add_period_q});
		if (state_q == ptt_pkg::ST_ADD) begin
			mem_wr.we = !valid_q[walk_q];
		end else if (ex_go) begin
			mem_wr.we        = 1'b1;
			mem_wr.period    = rd_period;
			mem_wr.remaining = fire ? $signed({2'b00, rd_period}) : diff;
		end
	end

	ptt_slot_mem #(
		.DEPTH  (SLOT_CAP),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk          (clk),
		.wr_addr      (walk_q),
		.wr           (mem_wr),
		.rd_en        (rd_en),
		.rd_addr      (walk_q),
		.rd_period    (rd_period),
		.rd_remaining (rd_remaining)
	);

	// sequencer and table marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptt_pkg::ST_IDLE;
			valid_q      <= '0;
			sleep_q      <= '0;
			once_q       <= '0;
			pending_q    <= '0;
			walk_q       <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ptt_pkg::ST_IDLE: begin
					if (in_valid) begin
						unique case (cmd)
							ptt_pkg::CMD_TICK: begin
								pending_q <= pending_q + 32'd1;
							end
							ptt_pkg::CMD_SERVICE: begin
								if (pending_q != '0) begin
									pending_q <= '0;
									walk_q    <= '0;
									state_q   <= ptt_pkg::ST_SVC_CHK;
								end
							end
							ptt_pkg::CMD_ADD: begin
								walk_q  <= '0;
								state_q <= ptt_pkg::ST_ADD;
							end
							ptt_pkg::CMD_REMOVE: begin
								hold_valid_q <= 1'b1;
								if (slot_hit) begin
									valid_q[slot_idx] <= 1'b0;
									sleep_q[slot_idx] <= 1'b0;
									once_q[slot_idx]  <= 1'b0;
								end
								state_q <= ptt_pkg::ST_FLUSH;
							end
							ptt_pkg::CMD_SLEEP: begin
								if (slot_hit) begin
									sleep_q[slot_idx] <= sleep_on;
								end else begin
									hold_valid_q <= 1'b1;
									state_q      <= ptt_pkg::ST_FLUSH;
								end
							end
							default: ;
						endcase
					end
				end
				ptt_pkg::ST_ADD: begin
					if (!valid_q[walk_q]) begin
						valid_q[walk_q] <= 1'b1;
						sleep_q[walk_q] <= 1'b0;
						once_q[walk_q]  <= add_once_q;
						hold_valid_q    <= 1'b1;
						state_q         <= ptt_pkg::ST_FLUSH;
					end else if (walk_end) begin
						hold_valid_q <= 1'b1;
						state_q      <= ptt_pkg::ST_FLUSH;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ptt_pkg::ST_SVC_CHK: begin
					if (active) begin
						state_q <= ptt_pkg::ST_SVC_EX;
					end else if (walk_end) begin
						state_q <= ptt_pkg::ST_FLUSH;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ptt_pkg::ST_SVC_EX: begin
					if (ex_go) begin
						// a new fire replaces the one just pushed out
						if (fire) begin
							hold_valid_q <= 1'b1;
						end
						if (fire && once_q[walk_q]) begin
							valid_q[walk_q] <= 1'b0;
							sleep_q[walk_q] <= 1'b0;
							once_q[walk_q]  <= 1'b0;
							state_q         <= ptt_pkg::ST_FLUSH;
						end else if (walk_end) begin
							state_q <= ptt_pkg::ST_FLUSH;
						end else begin
							walk_q  <= walk_q + 1'b1;
							state_q <= ptt_pkg::ST_SVC_CHK;
						end
					end
				end
				ptt_pkg::ST_FLUSH: begin
					if (!hold_valid_q) begin
						state_q <= ptt_pkg::ST_IDLE;
					end else if (out_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= ptt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ptt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// operand and held-result payload
	always_ff @(posedge clk) begin
		if (state_q == ptt_pkg::ST_IDLE && in_valid) begin
			elapsed_q    <= pending_q;
			add_period_q <= interval;
			add_once_q   <= one_shot;
			hold_id_q    <= slot;
			hold_kind_q  <= slot_hit && (cmd == ptt_pkg::CMD_REMOVE) ?
				ptt_pkg::KIND_REMOVED : ptt_pkg::KIND_INVALID;
		end else if (state_q == ptt_pkg::ST_ADD) begin
			if (!valid_q[walk_q]) begin
				hold_kind_q <= ptt_pkg::KIND_ADDED;
				hold_id_q   <= 4'(walk_q);
			end else begin
				hold_kind_q <= ptt_pkg::KIND_FULL;
				hold_id_q   <= '0;
			end
		end else if (ex_go && fire) begin
			hold_kind_q <= ptt_pkg::KIND_FIRED;
			hold_id_q   <= 4'(walk_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q <= hold_kind_q;
			out_id_q   <= hold_id_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign slot_id   = out_id_q;
	assign last      = out_last_q;

endmodule
`default_nettype wire

@@ hdl/ptt_checker.sv @@
// Port-level checker for the timer table, bound to the top level.
`default_nettype none
`include "periodic_task_timer_table_top_macros.svh"
module ptt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  cmd,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  kind,
	input wire logic [3:0]  slot_id,
	input wire logic        last
);

	// a stalled result holds
	`PTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(slot_id) && $stable(last), "stalled result changed")

	// table full reports slot zero as the only result
	`PTT_ASSERT_NOW(a_full_form, clk, arst_n, out_valid && kind == ptt_pkg::KIND_FULL, slot_id == 4'd0 && last, "malformed table full result")

	// add and remove give a single result
	`PTT_ASSERT_NOW(a_single, clk, arst_n, out_valid && (kind == ptt_pkg::KIND_ADDED || kind == ptt_pkg::KIND_REMOVED), last, "add or remove result not last")

	// an accepted add keeps the block busy for its slot search
	`PTT_ASSERT_NEXT(a_add_busy, clk, arst_n, in_valid && !in_stall && cmd == ptt_pkg::CMD_ADD, in_stall, "input taken during add")

endmodule

bind periodic_task_timer_table_top ptt_checker u_ptt_checker (.*);
`default_nettype wire
